@@ rtl/patch_block_deframer_crc32_top_defines.svh @@
// Assertion helpers shared by the deframer modules.
`ifndef PATCH_BLOCK_DEFRAMER_CRC32_TOP_DEFINES_SVH
`define PATCH_BLOCK_DEFRAMER_CRC32_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PBD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define PBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

@@ rtl/pbd_pkg.sv @@
package pbd_pkg;

   // Number of signature bytes that are checked (1 to 12).
   localparam int SIGNATURE_LENGTH = 12;
   localparam int SIG_INDEX_WIDTH  = 4;

   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
   localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;

   localparam logic [31:0] HEADER_FIELD_BYTES = 32'd4;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIG_HEAD = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIG_TAIL = 1'b1;

   // Result queue sizing.
   localparam int FIFO_DEPTH       = 4;
   localparam int FIFO_PTR_WIDTH   = $clog2(FIFO_DEPTH);
   localparam int FIFO_COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);
   localparam logic [FIFO_COUNT_WIDTH-1:0] COUNT_ONE       = FIFO_COUNT_WIDTH'(1);
   localparam logic [FIFO_COUNT_WIDTH-1:0] FIFO_FULL_COUNT = FIFO_COUNT_WIDTH'(FIFO_DEPTH);
   // A byte may produce two results, so two free slots are needed to process one.
   localparam logic [FIFO_COUNT_WIDTH-1:0] FIFO_ROOM_LIMIT = FIFO_COUNT_WIDTH'(FIFO_DEPTH - 2);

   typedef enum logic [5:0] {
      PH_SIG  = 6'b000001,
      PH_LEN  = 6'b000010,
      PH_TYPE = 6'b000100,
      PH_DATA = 6'b001000,
      PH_CRC  = 6'b010000,
      PH_SKIP = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_BAD_SIG = 2'd2,
      KIND_TRUNC   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [31:0] type_code;
      logic [31:0] block_length;
      logic [31:0] block_start;
      logic [31:0] crc_received;
      logic        crc_present;
      logic        crc_match;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic push0;
      logic push1;
   } push_type;

   // One byte of the reflected CRC-32 update.
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
      end
      return x;
   endfunction

   // Signature byte at a position, first byte taken from the top of the head register.
   function automatic logic [7:0] sig_byte(input logic [63:0] head, input logic [31:0] tail,
                                           input logic [SIG_INDEX_WIDTH-1:0] idx);
      logic [95:0] shifted;
      shifted = {head, tail} << {idx, 3'b000};
      return shifted[95:88];
   endfunction

endpackage

@@ rtl/pbd_req_if.sv @@
interface pbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source(output valid, output data_byte, output end_of_file, input ready);
   modport sink(input valid, input data_byte, input end_of_file, output ready);
endinterface

@@ rtl/pbd_rsp_if.sv @@
interface pbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic [31:0] type_code;
   logic [31:0] block_length;
   logic [31:0] block_start;
   logic [31:0] crc_received;
   logic        crc_present;
   logic        crc_match;
   logic        last_of_run;

   modport source(output valid, output kind, output payload_byte, output type_code,
                  output block_length, output block_start, output crc_received,
                  output crc_present, output crc_match, output last_of_run, input ready);
   modport sink(input valid, input kind, input payload_byte, input type_code,
                input block_length, input block_start, input crc_received,
                input crc_present, input crc_match, input last_of_run, output ready);
endinterface

@@ rtl/patch_block_deframer_crc32_top.sv @@
// Each byte word passes the input register, then the framing logic into the result queue,
// which it enters only with two free slots. Throughput: one byte word per cycle while the
// queue has room; a byte that ends a file on a payload byte gives two result words, and
// the output side then sets the pace at one result word per cycle.
// Reset: synchronous, active high; framing restarts with the signature, both signature
// registers clear to zero and the result queue empties.
module patch_block_deframer_crc32_top (
   input  logic                                clock,
   input  logic                                reset,
   pbd_req_if.sink                             req_chan,
   pbd_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [pbd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [63:0]                         csr_write_data
);
   import pbd_pkg::*;

   // Signature registers, to be written by the user only while the block is idle; the block does not enforce this.
   logic [63:0] sig_head_ff;
   logic [31:0] sig_tail_ff;

   // Input register: holds one byte word until the framing logic takes it.
   item_type    item_ff;
   logic        item_valid_ff;

   logic        has_room;
   logic        go;
   push_type    push;
   result_type  res0;
   result_type  res1;

   // The framing logic consumes the held word whenever the result queue has two
   // free slots. A new word is accepted in the same cycle that the held one moves
   // on, so a steady stream flows at one word per cycle.
   assign go             = item_valid_ff && has_room;
   assign req_chan.ready = !item_valid_ff || go;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         item_valid_ff <= 1'b1;
      end else if (go) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.data_byte   <= req_chan.data_byte;
         item_ff.end_of_file <= req_chan.end_of_file;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_head_ff <= '0;
         sig_tail_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SIG_HEAD: sig_head_ff <= csr_write_data;
            CSR_SIG_TAIL: sig_tail_ff <= csr_write_data[31:0];
            default: begin
            end
         endcase
      end
   end

   // Signature check, block framing and CRC; produces up to two result words per byte.
   pbd_deframe_core u_core (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .item     (item_ff),
      .sig_head (sig_head_ff),
      .sig_tail (sig_tail_ff),
      .push     (push),
      .res0     (res0),
      .res1     (res1)
   );

   // Result queue that decouples the framing logic from the output handshake.
   pbd_result_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .res0     (res0),
      .res1     (res1),
      .has_room (has_room),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ rtl/pbd_deframe_core.sv @@
`include "patch_block_deframer_crc32_top_defines.svh"

module pbd_deframe_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  pbd_pkg::item_type  item,
   input  logic [63:0]        sig_head,
   input  logic [31:0]        sig_tail,
   output pbd_pkg::push_type  push,
   output pbd_pkg::result_type res0,
   output pbd_pkg::result_type res1
);
   import pbd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] field_count_ff, field_count_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] type_ff, type_in;
   logic [31:0] crc_acc_ff, crc_acc_in;
   logic [31:0] crc_read_ff, crc_read_in;
   logic [31:0] file_offset_ff, file_offset_in;
   logic [31:0] start_ff, start_in;

   logic        main_valid, eof_valid;
   result_type  main_res, eof_res;
   logic [31:0] count_next;
   logic [31:0] length_base;
   logic [7:0]  b;

   always_comb begin
      b              = item.data_byte;
      phase_in       = phase_ff;
      field_count_in = field_count_ff;
      length_in      = length_ff;
      type_in        = type_ff;
      crc_acc_in     = crc_acc_ff;
      crc_read_in    = crc_read_ff;
      start_in       = start_ff;
      file_offset_in = file_offset_ff + 32'd1;
      count_next     = field_count_ff + 32'd1;
      length_base    = length_ff;
      main_valid     = 1'b0;
      eof_valid      = 1'b0;
      main_res       = '0;
      eof_res        = '0;

      case (phase_ff)
         PH_SIG: begin
            if (b != sig_byte(sig_head, sig_tail, field_count_ff[SIG_INDEX_WIDTH-1:0])) begin
               main_valid    = 1'b1;
               main_res.kind = KIND_BAD_SIG;
               phase_in      = PH_SKIP;
            end else if (count_next >= 32'(SIGNATURE_LENGTH)) begin
               field_count_in = '0;
               phase_in       = PH_LEN;
            end else begin
               field_count_in = count_next;
            end
         end
         PH_LEN: begin
            // The first size byte opens a new block.
            if (field_count_ff == '0) begin
               start_in    = file_offset_ff;
               length_base = '0;
               type_in     = '0;
               crc_read_in = '0;
               crc_acc_in  = CRC_INIT;
            end
            length_in = {length_base[23:0], b};
            if (count_next >= HEADER_FIELD_BYTES) begin
               field_count_in = '0;
               phase_in       = PH_TYPE;
            end else begin
               field_count_in = count_next;
            end
         end
         PH_TYPE: begin
            case (field_count_ff[1:0])
               2'd0:    type_in[7:0]   = b;
               2'd1:    type_in[15:8]  = b;
               2'd2:    type_in[23:16] = b;
               default: type_in[31:24] = b;
            endcase
            crc_acc_in = crc_byte(crc_acc_ff, b);
            if (count_next >= HEADER_FIELD_BYTES) begin
               field_count_in = '0;
               phase_in       = (length_ff == '0) ? PH_CRC : PH_DATA;
            end else begin
               field_count_in = count_next;
            end
         end
         PH_DATA: begin
            main_valid            = 1'b1;
            main_res.kind         = KIND_PAYLOAD;
            main_res.payload_byte = b;
            crc_acc_in            = crc_byte(crc_acc_ff, b);
            if (count_next >= length_ff) begin
               field_count_in = '0;
               phase_in       = PH_CRC;
            end else begin
               field_count_in = count_next;
            end
         end
         PH_CRC: begin
            crc_read_in = {crc_read_ff[23:0], b};
            if (count_next >= HEADER_FIELD_BYTES) begin
               main_valid            = 1'b1;
               main_res.kind         = KIND_DONE;
               main_res.type_code    = type_ff;
               main_res.block_length = length_ff;
               main_res.block_start  = start_ff;
               main_res.crc_received = crc_read_in;
               main_res.crc_present  = 1'b1;
               main_res.crc_match    = ((crc_acc_ff ^ CRC_XOROUT) == crc_read_in);
               field_count_in        = '0;
               phase_in              = PH_LEN;
            end else begin
               field_count_in = count_next;
            end
         end
         default: begin
         end
      endcase

      if (item.end_of_file) begin
         case (phase_in)
            PH_SIG: begin
               eof_valid    = 1'b1;
               eof_res.kind = KIND_BAD_SIG;
            end
            PH_LEN: begin
               if (field_count_in != '0) begin
                  eof_valid           = 1'b1;
                  eof_res.kind        = KIND_TRUNC;
                  eof_res.block_start = start_in;
               end
            end
            PH_TYPE: begin
               eof_valid            = 1'b1;
               eof_res.kind         = KIND_TRUNC;
               eof_res.block_length = length_in;
               eof_res.block_start  = start_in;
            end
            PH_DATA: begin
               eof_valid            = 1'b1;
               eof_res.kind         = KIND_TRUNC;
               eof_res.type_code    = type_in;
               eof_res.block_length = length_in;
               eof_res.block_start  = start_in;
            end
            PH_CRC: begin
               eof_valid            = 1'b1;
               eof_res.kind         = KIND_DONE;
               eof_res.type_code    = type_in;
               eof_res.block_length = length_in;
               eof_res.block_start  = start_in;
            end
            default: begin
            end
         endcase
         // The next byte begins a new file.
         phase_in       = PH_SIG;
         field_count_in = '0;
         length_in      = '0;
         type_in        = '0;
         crc_acc_in     = CRC_INIT;
         crc_read_in    = '0;
         file_offset_in = '0;
         start_in       = '0;
      end

      main_res.last_of_run = !eof_valid;
      eof_res.last_of_run  = 1'b1;

      push.push0 = go && (main_valid || eof_valid);
      push.push1 = go && main_valid && eof_valid;
      res0       = main_valid ? main_res : eof_res;
      res1       = eof_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SIG;
         field_count_ff <= '0;
         length_ff      <= '0;
         type_ff        <= '0;
         crc_acc_ff     <= CRC_INIT;
         crc_read_ff    <= '0;
         file_offset_ff <= '0;
         start_ff       <= '0;
      end else if (go) begin
         phase_ff       <= phase_in;
         field_count_ff <= field_count_in;
         length_ff      <= length_in;
         type_ff        <= type_in;
         crc_acc_ff     <= crc_acc_in;
         crc_read_ff    <= crc_read_in;
         file_offset_ff <= file_offset_in;
         start_ff       <= start_in;
      end
   end

   `PBD_ASSERT_IMPLIES(a_data_gives_payload, clock, reset, go && phase_ff == PH_DATA, push.push0 && res0.kind == KIND_PAYLOAD)
   `PBD_ASSERT_IMPLIES(a_pair_only_at_eof, clock, reset, push.push1, push.push0 && item.end_of_file && !res0.last_of_run)
   `PBD_ASSERT_NEXT(a_eof_restarts_file, clock, reset, go && item.end_of_file, phase_ff == PH_SIG && file_offset_ff == '0)

endmodule

@@ rtl/pbd_result_fifo.sv @@
`include "patch_block_deframer_crc32_top_defines.svh"

module pbd_result_fifo (
   input  logic                clock,
   input  logic                reset,
   input  pbd_pkg::push_type   push,
   input  pbd_pkg::result_type res0,
   input  pbd_pkg::result_type res1,
   output logic                has_room,
   pbd_rsp_if.source           rsp_chan
);
   import pbd_pkg::*;

   result_type entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_WIDTH-1:0]   head_ff, head_in;
   logic [FIFO_PTR_WIDTH-1:0]   tail_ff, tail_in;
   logic [FIFO_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [FIFO_PTR_WIDTH-1:0]   tail_next;
   logic                        pop;
   result_type                  head_word;

   assign tail_next = tail_ff + FIFO_PTR_WIDTH'(1);
   assign pop       = rsp_chan.valid && rsp_chan.ready;
   // Room is judged on the stored count only, so ready never depends on rsp ready.
   assign has_room  = (count_ff <= FIFO_ROOM_LIMIT);

   always_comb begin
      head_in  = pop ? head_ff + FIFO_PTR_WIDTH'(1) : head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push.push1) begin
         tail_in = tail_ff + FIFO_PTR_WIDTH'(2);
      end else if (push.push0) begin
         tail_in = tail_next;
      end
      if (push.push0) begin
         count_in = count_in + COUNT_ONE;
      end
      if (push.push1) begin
         count_in = count_in + COUNT_ONE;
      end
      if (pop) begin
         count_in = count_in - COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         entry_ff[tail_ff] <= res0;
      end
      if (push.push1) begin
         entry_ff[tail_next] <= res1;
      end
   end

   assign head_word             = entry_ff[head_ff];
   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.kind         = head_word.kind;
   assign rsp_chan.payload_byte = head_word.payload_byte;
   assign rsp_chan.type_code    = head_word.type_code;
   assign rsp_chan.block_length = head_word.block_length;
   assign rsp_chan.block_start  = head_word.block_start;
   assign rsp_chan.crc_received = head_word.crc_received;
   assign rsp_chan.crc_present  = head_word.crc_present;
   assign rsp_chan.crc_match    = head_word.crc_match;
   assign rsp_chan.last_of_run  = head_word.last_of_run;

   `PBD_ASSERT_IMPLIES(a_count_bounded, clock, reset, 1'b1, count_ff <= FIFO_FULL_COUNT)
   `PBD_ASSERT_IMPLIES(a_push_has_room, clock, reset, push.push0, count_ff <= FIFO_ROOM_LIMIT)
   `PBD_ASSERT_NEXT(a_pop_drains_one, clock, reset, pop && !push.push0, count_ff + COUNT_ONE == $past(count_ff))

endmodule

@@ test/pbd_tb_pkg.sv @@
package pbd_tb_pkg;
   import pbd_pkg::*;

   // Reflected CRC-32, one byte, fed in bit by bit from the least significant end.
   function automatic logic [31:0] crc32_advance(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      logic        feedback;
      c = acc;
      for (int i = 0; i < 8; i++) begin
         feedback = c[0] ^ b[i];
         c = c >> 1;
         if (feedback) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   // Tracks the deframer's framing state and holds the result words still owed by it.
   class frame_tracker;
      logic [63:0] sig_head;
      logic [31:0] sig_tail;
      phase_type   phase;
      logic [31:0] count;
      logic [31:0] length;
      logic [31:0] btype;
      logic [31:0] crc_acc;
      logic [31:0] crc_rx;
      logic [31:0] offset;
      logic [31:0] start;
      result_type  awaiting[$];
      int unsigned mismatches;
      int unsigned words_checked;
      int unsigned good_crc;
      int unsigned bad_crc;
      int unsigned no_crc;
      int unsigned truncated;
      int unsigned bad_sig;

      function new();
         sig_head = '0;
         sig_tail = '0;
         restart();
      endfunction

      function void restart();
         phase   = PH_SIG;
         count   = '0;
         length  = '0;
         btype   = '0;
         crc_acc = CRC_INIT;
         crc_rx  = '0;
         offset  = '0;
         start   = '0;
      endfunction

      function void set_signature(input logic [63:0] head, input logic [31:0] tail);
         sig_head = head;
         sig_tail = tail;
      endfunction

      function logic [7:0] expected_sig_byte(input int idx);
         logic [95:0] all;
         all = {sig_head, sig_tail};
         return all[95 - 8 * idx -: 8];
      endfunction

      function result_type make_record(input kind_type k, input logic [7:0] pb,
                                       input logic [31:0] ty, input logic [31:0] len,
                                       input logic [31:0] st, input logic [31:0] crc,
                                       input logic present, input logic match);
         result_type r;
         r.kind         = k;
         r.payload_byte = pb;
         r.type_code    = ty;
         r.block_length = len;
         r.block_start  = st;
         r.crc_received = crc;
         r.crc_present  = present;
         r.crc_match    = match;
         r.last_of_run  = 1'b0;
         return r;
      endfunction

      function void absorb_byte(input logic [7:0] b, input logic eof);
         result_type  made[$];
         result_type  w;
         logic [31:0] here;
         here   = offset;
         offset = offset + 32'd1;
         case (phase)
            PH_SIG: begin
               if (b != expected_sig_byte(int'(count))) begin
                  made = {made, make_record(KIND_BAD_SIG, 0, 0, 0, 0, 0, 0, 0)};
                  phase = PH_SKIP;
               end else begin
                  count++;
                  if (count >= SIGNATURE_LENGTH) begin
                     phase = PH_LEN;
                     count = '0;
                  end
               end
            end
            PH_LEN: begin
               if (count == 0) begin
                  start   = here;
                  length  = '0;
                  btype   = '0;
                  crc_rx  = '0;
                  crc_acc = CRC_INIT;
               end
               length = {length[23:0], b};
               count++;
               if (count >= HEADER_FIELD_BYTES) begin
                  count = '0;
                  phase = PH_TYPE;
               end
            end
            PH_TYPE: begin
               btype   = btype | ({24'd0, b} << (8 * count[1:0]));
               crc_acc = crc32_advance(crc_acc, b);
               count++;
               if (count >= HEADER_FIELD_BYTES) begin
                  count = '0;
                  phase = (length == 0) ? PH_CRC : PH_DATA;
               end
            end
            PH_DATA: begin
               made = {made, make_record(KIND_PAYLOAD, b, 0, 0, 0, 0, 0, 0)};
               crc_acc = crc32_advance(crc_acc, b);
               count++;
               if (count >= length) begin
                  count = '0;
                  phase = PH_CRC;
               end
            end
            PH_CRC: begin
               crc_rx = {crc_rx[23:0], b};
               count++;
               if (count >= HEADER_FIELD_BYTES) begin
                  made = {made, make_record(KIND_DONE, 0, btype, length, start, crc_rx, 1'b1,
                                            (crc_acc ^ CRC_XOROUT) == crc_rx)};
                  count = '0;
                  phase = PH_LEN;
               end
            end
            default: ;
         endcase

         if (eof) begin
            case (phase)
               PH_SIG:  made = {made, make_record(KIND_BAD_SIG, 0, 0, 0, 0, 0, 0, 0)};
               PH_LEN: begin
                  if (count != 0)
                     made = {made, make_record(KIND_TRUNC, 0, 0, 0, start, 0, 0, 0)};
               end
               PH_TYPE: made = {made, make_record(KIND_TRUNC, 0, 0, length, start, 0, 0, 0)};
               PH_DATA: made = {made, make_record(KIND_TRUNC, 0, btype, length, start, 0, 0, 0)};
               PH_CRC:  made = {made, make_record(KIND_DONE, 0, btype, length, start, 0, 0, 0)};
               default: ;
            endcase
            restart();
         end

         foreach (made[i]) begin
            w = made[i];
            w.last_of_run = (i == made.size() - 1);
            awaiting = {awaiting, w};
         end
      endfunction

      function int outstanding();
         return awaiting.size();
      endfunction

      function string describe(input result_type r);
         return $sformatf({"kind=%0d byte=%02h type=%08h len=%08h start=%08h crc=%08h",
                           " p=%0b m=%0b last=%0b"},
                          r.kind, r.payload_byte, r.type_code, r.block_length, r.block_start,
                          r.crc_received, r.crc_present, r.crc_match, r.last_of_run);
      endfunction

      function void report(input string what);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", what);
      endfunction

      function void check_word(input result_type got);
         result_type want;
         words_checked++;
         if (awaiting.size() == 0) begin
            report($sformatf("unexpected word %s", describe(got)));
            return;
         end
         want = awaiting.pop_front();
         case (want.kind)
            KIND_DONE: begin
               if (!want.crc_present) no_crc++;
               else if (want.crc_match) good_crc++;
               else bad_crc++;
            end
            KIND_TRUNC:   truncated++;
            KIND_BAD_SIG: bad_sig++;
            default: ;
         endcase
         if (got !== want) begin
            report($sformatf("word %0d\n   expected %s\n   actual   %s", words_checked,
                             describe(want), describe(got)));
         end
      endfunction

      // Anything still owed at the end of the run is a failure.
      function void close_out();
         if (awaiting.size() != 0) begin
            report($sformatf("%0d expected words never arrived, first %s", awaiting.size(),
                             describe(awaiting[0])));
            mismatches += awaiting.size() - 1;
         end
      endfunction
   endclass

endpackage

@@ test/patch_block_deframer_crc32_top_tb.sv @@
module patch_block_deframer_crc32_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pbd_pkg::*;
   import pbd_tb_pkg::*;

   // Cycles in a row with no word moving on either channel before the run is abandoned.
   // A correct run never comes close: the longest sender gap and the longest receiver
   // stall are both far shorter.
   localparam int QUIET_LIMIT = 2000;
   // Cycles allowed after the last owed word before touching the signature registers.
   // The last byte only has to clear the input register and the framing logic within it.
   localparam int SETTLE_CYCLES = 6;
   localparam int SETTINGS_COUNT = 6;
   localparam int BYTES_PER_SETTING = 220;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [63:0]                csr_write_data;

   pbd_req_if req_chan();
   pbd_rsp_if rsp_chan();

   patch_block_deframer_crc32_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // The tracker predicts every result word and holds them until the block delivers them.
   frame_tracker frames = new();

   // Bytes of the file being built; the last one is sent with the end-of-file flag.
   logic [7:0]  file_image[$];
   int unsigned burst_left = 0;
   int unsigned bytes_sent = 0;
   int unsigned files_sent = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------------

   // Offers one byte word and returns at the edge where it was taken. The sender runs in
   // bursts; when a burst is used up it drops valid for a random gap and starts another.
   // Valid gets exactly one assignment in any time step, so a word that follows straight
   // on keeps valid high without a glitch.
   task automatic push_byte(input logic [7:0] b, input logic eof);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
         case ($urandom_range(0, 5))
            0:       gap = 0;
            1:       gap = $urandom_range(6, 12);
            default: gap = $urandom_range(1, 5);
         endcase
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= b;
      req_chan.end_of_file <= eof;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      frames.absorb_byte(b, eof);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_image[i]) push_byte(file_image[i], i == file_image.size() - 1);
      files_sent++;
   endtask

   // Lets every owed word arrive, then waits out the settling margin so that a final
   // byte that caused no result has surely left the pipeline.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (frames.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both signature registers back to back; called only with the block idle.
   task automatic program_signature(input logic [63:0] head, input logic [31:0] tail);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SIG_HEAD;
      csr_write_data   <= head;
      @(posedge clock);
      csr_index        <= CSR_SIG_TAIL;
      csr_write_data   <= {32'd0, tail};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      frames.set_signature(head, tail);
   endtask

   // ---------------------------------------------------------------------------------
   // File building
   // ---------------------------------------------------------------------------------

   function automatic void put_word_be(input logic [31:0] v);
      for (int i = 3; i >= 0; i--) file_image = {file_image, v[8 * i +: 8]};
   endfunction

   // The first n bytes of the signature currently programmed into the block.
   function automatic void put_signature(input int n);
      for (int i = 0; i < n; i++) file_image = {file_image, frames.expected_sig_byte(i)};
   endfunction

   // One block with a size field, random type and payload, and a CRC that is correct
   // unless spoiled. The payload written may be shorter than the size field claims.
   function automatic void put_block(input logic [31:0] size_field, input int body,
                                     input bit spoil);
      logic [31:0] acc;
      logic [7:0]  t;
      put_word_be(size_field);
      acc = CRC_INIT;
      for (int i = 0; i < 4 + body; i++) begin
         t = 8'($urandom);
         file_image = {file_image, t};
         acc = crc32_advance(acc, t);
      end
      acc = acc ^ CRC_XOROUT;
      if (spoil) acc = acc ^ (32'd1 << $urandom_range(0, 31));
      put_word_be(acc);
   endfunction

   function automatic int pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(0, 4);
      if (r < 92) return $urandom_range(5, 16);
      return $urandom_range(17, 40);
   endfunction

   function automatic void trim_to(input int keep);
      while (file_image.size() > keep) void'(file_image.pop_back());
   endfunction

   // Most files are well formed, so the framing logic sees whole blocks, good and bad
   // CRCs and every truncation point. The rest are broken or short signatures, files
   // that claim huge payloads, and plain noise.
   task automatic send_random_file();
      int unsigned pick;
      int          len;
      int          prefix;
      pick = $urandom_range(0, 99);
      file_image.delete();
      if (pick < 60) begin
         put_signature(SIGNATURE_LENGTH);
         repeat ($urandom_range(1, 3)) begin
            len = pick_length();
            put_block(32'(len), len, $urandom_range(0, 4) == 0);
         end
         // Half of these files end cleanly on a CRC byte; the others stop anywhere after
         // the signature, which may land in any field of any block.
         if ($urandom_range(0, 1) == 0)
            trim_to($urandom_range(SIGNATURE_LENGTH, file_image.size() - 1));
      end else if (pick < 70) begin
         put_signature(SIGNATURE_LENGTH);
         put_block({8'($urandom_range(1, 255)), 24'($urandom)}, $urandom_range(1, 6), 1'b0);
         trim_to($urandom_range(SIGNATURE_LENGTH + 1, file_image.size()));
      end else if (pick < 82) begin
         prefix = $urandom_range(0, SIGNATURE_LENGTH - 1);
         put_signature(prefix);
         file_image = {file_image,
                       frames.expected_sig_byte(prefix) ^ 8'($urandom_range(1, 255))};
         repeat ($urandom_range(0, 10)) file_image = {file_image, 8'($urandom)};
      end else if (pick < 90) begin
         put_signature($urandom_range(1, SIGNATURE_LENGTH - 1));
      end else begin
         repeat ($urandom_range(1, 20)) file_image = {file_image, 8'($urandom)};
      end
      send_file();
   endtask

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------

   initial begin
      int unsigned phase_start;
      logic [63:0] head;
      logic [31:0] tail;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.data_byte   <= 8'd0;
      req_chan.end_of_file <= 1'b0;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_SIG_HEAD;
      csr_write_data       <= 64'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int s = 0; s < SETTINGS_COUNT; s++) begin
         // The first setting is the all-zero signature, the second all ones, and the
         // remaining ones are random.
         case (s)
            0: begin
               head = '0;
               tail = '0;
            end
            1: begin
               head = '1;
               tail = '1;
            end
            default: begin
               head = {$urandom, $urandom};
               tail = $urandom;
            end
         endcase
         program_signature(head, tail);

         if (s == 0) begin
            // A wrong first byte that is also the end of the file.
            file_image = '{8'hFF};
            send_file();
            // A matching first byte that ends the file before the signature is complete.
            file_image = '{8'h00};
            send_file();
            // A full signature, a one-byte block with an all-ones type, cut off after its only
            // payload byte: one payload word and one done word without CRC from one byte.
            file_image.delete();
            put_signature(SIGNATURE_LENGTH);
            put_word_be(32'd1);
            repeat (5) file_image = {file_image, 8'hFF};
            send_file();
         end

         phase_start = bytes_sent;
         while (bytes_sent - phase_start < BYTES_PER_SETTING) send_random_file();
         drain();
      end

      frames.close_out();
      $display("Ran %0d bytes in %0d files under %0d signature settings, %0d words checked.",
               bytes_sent, files_sent, SETTINGS_COUNT, frames.words_checked);
      $display("Blocks: %0d good CRC, %0d bad CRC, %0d without CRC, %0d truncated; %0d bad signatures.",
               frames.good_crc, frames.bad_crc, frames.no_crc, frames.truncated, frames.bad_sig);
      if (frames.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches in total.", frames.mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Receiver side
   // ---------------------------------------------------------------------------------

   // Ready follows a rotating 16-bit pattern that is replaced when its random life runs out.
   // About a quarter of the patterns are all ones, giving stretches without stalls; the
   // others always hold at least one high bit, so no stall lasts a full rotation.
   initial begin
      logic [15:0] stall_pattern;
      int unsigned pattern_life;
      result_type  got;
      stall_pattern = '1;
      pattern_life  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind         = kind_type'(rsp_chan.kind);
            got.payload_byte = rsp_chan.payload_byte;
            got.type_code    = rsp_chan.type_code;
            got.block_length = rsp_chan.block_length;
            got.block_start  = rsp_chan.block_start;
            got.crc_received = rsp_chan.crc_received;
            got.crc_present  = rsp_chan.crc_present;
            got.crc_match    = rsp_chan.crc_match;
            got.last_of_run  = rsp_chan.last_of_run;
            frames.check_word(got);
         end
         if (pattern_life == 0) begin
            pattern_life  = $urandom_range(64, 256);
            stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : (16'($urandom) | 16'h0001);
         end
         pattern_life--;
         rsp_chan.ready <= stall_pattern[0];
         stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   // ---------------------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------------------

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Watchdog: no word moved for %0d cycles.", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

endmodule
